### hw/rtl/wpms_pkg.sv
`timescale 1ns / 1ps

package wpms_pkg;

   // deepest window the cell row supports
   localparam int MAX_WINDOW = 16;

   localparam int VALUE_W  = 16;
   localparam int SUM_W    = 32;
   localparam int WINDOW_W = 5;
   // counts 0 .. MAX_WINDOW
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int PROD_W   = VALUE_W + CNT_W;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // partial result that walks down the cell row
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] run_max;
      logic [SUM_W-1:0]   best;
   } token_type;

   // shared controls for every cell
   typedef struct packed {
      logic shift_value;
      logic shift_sum;
      logic clear;
   } cell_ctrl_type;

endpackage

### hw/rtl/wpms_cell.sv
`timescale 1ns / 1ps

module wpms_cell import wpms_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]   cell_index,
   input  logic [CNT_W-1:0]   span,
   input  logic [VALUE_W-1:0] value_in,
   input  logic [SUM_W-1:0]   sum_in,
   input  token_type          tok_in,
   output logic [VALUE_W-1:0] value_out,
   output logic [SUM_W-1:0]   sum_out,
   output token_type          tok_out
);

   logic [VALUE_W-1:0] value_ff;
   logic [SUM_W-1:0]   sum_ff;
   token_type          tok_ff;
   token_type          tok_in_next;

   logic               active;
   logic [VALUE_W-1:0] run_max;
   logic [CNT_W-1:0]   weight;
   logic [PROD_W-1:0]  prod;
   logic [SUM_W:0]     cand_wide;
   logic [SUM_W-1:0]   cand;

   // segment ending here covers cell_index + 1 elements
   always_comb begin
      active    = (cell_index < span);
      run_max   = (value_ff > tok_in.run_max) ? value_ff : tok_in.run_max;
      weight    = cell_index + CNT_W'(1);
      prod      = PROD_W'(run_max) * PROD_W'(weight);
      cand_wide = {1'b0, sum_ff} + (SUM_W + 1)'(prod);
      cand      = cand_wide[SUM_W] ? SUM_MAX : cand_wide[SUM_W-1:0];

      tok_in_next       = tok_in;
      if (active) begin
         tok_in_next.run_max = run_max;
         tok_in_next.best    = (cand > tok_in.best) ? cand : tok_in.best;
      end
   end

   // advance the token one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.run_max <= tok_in_next.run_max;
      tok_ff.best    <= tok_in_next.best;
   end

   // hold the window slot; shift from the neighbor or drop on array end
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         sum_ff   <= '0;
      end else begin
         priority if (ctrl.clear) begin
            value_ff <= '0;
            sum_ff   <= '0;
         end else begin
            if (ctrl.shift_value) begin
               value_ff <= value_in;
            end
            if (ctrl.shift_sum) begin
               sum_ff <= sum_in;
            end
         end
      end
   end

   assign value_out = value_ff;
   assign sum_out   = sum_ff;
   assign tok_out   = tok_ff;

endmodule

### hw/rtl/window_partition_max_sum.sv
`timescale 1ns / 1ps

// Streaming best partition sum. Array elements enter on the req_ channel, one
// transfer per element; req_tlast marks the last element of an array. Each
// element yields one transfer on the rsp_ channel carrying the best sum for the
// prefix so far, with rsp_tlast set on the answer for the whole array, after
// which the window history clears for the next array.
// csr_write_en / csr_write_data set the largest segment length (1..16; 0 acts
// as 1, larger values as 16). Write it only while no element is in flight.
// The element shifts into cell 0 at the transfer, then a token runs down a row
// of 16 cells, one cell per cycle, each cell within the current span adding one
// candidate segment length, followed by the holding stage and the output
// register. The next element depends on this result, so one element is in
// flight at a time and no new element is taken until the result has moved
// from the holding stage into the output register.
// The result sits in an output register; while the receiver stalls, one more
// element can be taken and finished into a holding stage, then req_tready
// stays low until the output register frees up.
// Reset clears the history and sets the segment length to 1.
module window_partition_max_sum import wpms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [WINDOW_W-1:0] csr_write_data,  // window_size
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,       // [15:0] element_value
   input  logic                req_tlast,       // last_element
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,       // [31:0] prefix_best_sum
   output logic                rsp_tlast        // is_final
);

   logic [WINDOW_W-1:0] window_ff;
   logic                busy_ff;
   logic                head_valid_ff;
   logic                last_ff;
   logic [CNT_W-1:0]    span_ff;
   logic [CNT_W-1:0]    span_in;
   logic [CNT_W-1:0]    items_ff;
   logic [CNT_W-1:0]    k_eff;
   logic [CNT_W:0]      items_plus;

   logic                pend_valid_ff;
   logic [SUM_W-1:0]    pend_sum_ff;
   logic                pend_last_ff;
   logic                rsp_valid_ff;
   logic [SUM_W-1:0]    rsp_sum_ff;
   logic                rsp_last_ff;

   logic                req_xfer;
   logic                tok_exit;
   logic                pend_move;
   cell_ctrl_type       ctrl;
   token_type           head_tok;

   logic [VALUE_W-1:0]  value_vec [MAX_WINDOW];
   logic [SUM_W-1:0]    sum_vec   [MAX_WINDOW];
   token_type           tok_vec   [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] tok_valid;

   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && !busy_ff;
   assign tok_exit   = tok_vec[MAX_WINDOW-1].valid;
   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   // clamp the window and limit it by the elements seen
   always_comb begin
      if (window_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         k_eff = CNT_W'(MAX_WINDOW);
      end else begin
         k_eff = CNT_W'(window_ff);
      end
      items_plus = {1'b0, items_ff} + (CNT_W + 1)'(1);
      span_in    = (items_plus > (CNT_W + 1)'(k_eff)) ? k_eff : items_plus[CNT_W-1:0];
   end

   // fresh token for cell 0
   always_comb begin
      head_tok.valid   = head_valid_ff;
      head_tok.run_max = '0;
      head_tok.best    = '0;
      ctrl.shift_value = req_xfer;
      ctrl.shift_sum   = tok_exit && !last_ff;
      ctrl.clear       = tok_exit && last_ff;
   end

   // start the token once the element has shifted into cell 0
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= req_xfer;
      end
   end

   // row of cells
   for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
      if (j == 0) begin : g_head
         wpms_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cell_index (CNT_W'(j)),
            .span       (span_ff),
            .value_in   (req_tdata[VALUE_W-1:0]),
            .sum_in     (tok_vec[MAX_WINDOW-1].best),
            .tok_in     (head_tok),
            .value_out  (value_vec[j]),
            .sum_out    (sum_vec[j]),
            .tok_out    (tok_vec[j])
         );
      end else begin : g_body
         wpms_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cell_index (CNT_W'(j)),
            .span       (span_ff),
            .value_in   (value_vec[j-1]),
            .sum_in     (sum_vec[j-1]),
            .tok_in     (tok_vec[j-1]),
            .value_out  (value_vec[j]),
            .sum_out    (sum_vec[j]),
            .tok_out    (tok_vec[j])
         );
      end
      assign tok_valid[j] = tok_vec[j].valid;
   end

   // window register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_W'(1);
      end else if (csr_write_en) begin
         window_ff <= csr_write_data;
      end
   end

   // one element in flight: hold busy from transfer until the result moves out
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         items_ff <= '0;
      end else begin
         if (req_xfer) begin
            busy_ff <= 1'b1;
         end else if (pend_move) begin
            busy_ff <= 1'b0;
         end
         if (tok_exit) begin
            if (last_ff) begin
               items_ff <= '0;
            end else if (items_ff < CNT_W'(MAX_WINDOW)) begin
               items_ff <= items_ff + CNT_W'(1);
            end
         end
      end
   end

   // capture per-element control at transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         last_ff <= req_tlast;
         span_ff <= span_in;
      end
   end

   // holding stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (tok_exit) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (tok_exit) begin
         pend_sum_ff  <= tok_vec[MAX_WINDOW-1].best;
         pend_last_ff <= last_ff;
      end
      if (pend_move) begin
         rsp_sum_ff  <= pend_sum_ff;
         rsp_last_ff <= pend_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> busy_ff)
      else $error("busy not set after input transfer");

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one token in the cell row");

   a_exit_while_busy: assert property (@(posedge clock) disable iff (reset)
      tok_exit |-> (busy_ff && !pend_valid_ff))
      else $error("token left the row with no element in flight or holding stage full");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff)
      else $error("holding stage full while idle");

endmodule

### tb/sv/tb_window_partition_max_sum.sv
`timescale 1ns / 1ps

module tb_window_partition_max_sum;
   import wpms_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   // comfortably past the time one element takes through the block
   localparam int SETTLE_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int RANDOM_ITEMS     = 1000;
   // long enough to keep every cell of the row active for many elements
   localparam int LONG_ARRAY_ITEMS = 100;
   localparam int DRAIN_LIMIT      = 100000;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             is_final;
   } prefix_result_type;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [WINDOW_W-1:0] csr_write_data;
   logic                req_tvalid;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [SUM_W-1:0]    rsp_tdata;
   logic                rsp_tlast;

   // running copy of the block's history and window register
   logic [VALUE_W-1:0]  hist_values [MAX_WINDOW];
   logic [SUM_W-1:0]    hist_best [MAX_WINDOW];
   int unsigned         hist_count;
   logic [WINDOW_W-1:0] window_setting;

   prefix_result_type   pending_results [$];
   int unsigned         fail_count;
   int unsigned         result_index;
   int unsigned         burst_left;
   bit                  sender_steady;
   bit                  rx_steady;
   bit                  hold_off_request;

   window_partition_max_sum uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // end a hung run
   initial begin
      #(60_000_000);
      $display("Regression FAIL");
      $finish;
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   // empty the history for a new array
   function automatic void clear_history();
      for (int j = 0; j < MAX_WINDOW; j++) begin
         hist_values[j] = '0;
         hist_best[j]   = '0;
      end
      hist_count = 0;
   endfunction

   // best partition sum of the prefix after taking one more element
   function automatic prefix_result_type predict_prefix_best(input logic [VALUE_W-1:0] elem,
                                                             input logic last);
      int unsigned    k;
      int unsigned    span;
      logic [63:0]    cand;
      logic [63:0]    best;
      logic [VALUE_W-1:0] run_max;
      prefix_result_type r;
      k = window_setting;
      if (k == 0) k = 1;
      if (k > MAX_WINDOW) k = MAX_WINDOW;
      for (int j = MAX_WINDOW - 1; j > 0; j--) hist_values[j] = hist_values[j - 1];
      hist_values[0] = elem;
      span = (hist_count + 1 > k) ? k : hist_count + 1;
      run_max = '0;
      best = '0;
      // one candidate per length of the segment that ends at this element
      for (int j = 0; j < span; j++) begin
         if (hist_values[j] > run_max) run_max = hist_values[j];
         cand = 64'(hist_best[j]) + 64'(j + 1) * 64'(run_max);
         if (cand > 64'(SUM_MAX)) cand = 64'(SUM_MAX);
         if (cand > best) best = cand;
      end
      r.sum      = best[SUM_W-1:0];
      r.is_final = last;
      if (last) begin
         clear_history();
      end else begin
         for (int j = MAX_WINDOW - 1; j > 0; j--) hist_best[j] = hist_best[j - 1];
         hist_best[0] = best[SUM_W-1:0];
         if (hist_count < MAX_WINDOW) hist_count++;
      end
      return r;
   endfunction

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin
      prefix_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("result %0d with nothing pending: sum %0d final %0b",
                                   result_index, rsp_tdata, rsp_tlast));
         end else begin
            want = pending_results.pop_front();
            if (want.sum !== rsp_tdata || want.is_final !== rsp_tlast) begin
               note_failure($sformatf("result %0d: expected sum %0d final %0b, got sum %0d final %0b",
                                      result_index, want.sum, want.is_final,
                                      rsp_tdata, rsp_tlast));
            end
         end
         result_index++;
      end
   end

   // receiver: switch between stall patterns, or hold off on request
   initial begin : receiver
      rx_mode_type mode;
      int unsigned mode_left;
      int unsigned phase;
      rsp_tready = 1'b0;
      mode = RX_ALWAYS;
      mode_left = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            phase++;
            if (rx_steady) begin
               rsp_tready <= 1'b1;
            end else begin
               case (mode)
                  RX_ALWAYS:   rsp_tready <= 1'b1;
                  RX_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
                  RX_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
                  default:     rsp_tready <= (phase % 5 != 0);
               endcase
            end
         end
      end
   end

   // insert a random gap after a burst of transfers
   task automatic pace_sender();
      int unsigned gap;
      if (sender_steady) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 45) : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // offer one element and hold it until the transfer happens
   task automatic send_element(input logic [VALUE_W-1:0] value, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_prefix_best(value, last));
      @(negedge clock);
      pace_sender();
   endtask

   // stop offering and wait for every pending result
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_window(input logic [WINDOW_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      window_setting = value;
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_element();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return VALUE_W'($urandom_range(0, 15));
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [WINDOW_W-1:0] pick_window();
      case ($urandom_range(0, 5))
         0:       return WINDOW_W'(1);
         1:       return WINDOW_W'(MAX_WINDOW);
         2:       return $urandom_range(0, 1) ? '1 : '0;
         default: return WINDOW_W'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 9))
         0:       return 1;
         1:       return $urandom_range(25, 40);
         default: return $urandom_range(2, 20);
      endcase
   endfunction

   // window stays at its reset value of one
   task automatic test_reset_window();
      send_element(16'd7, 1'b0);
      send_element(16'd0, 1'b0);
      send_element(16'hFFFF, 1'b1);
   endtask

   // zero acts as one, values past the cell row act as the full row
   task automatic test_window_clamp();
      logic [VALUE_W-1:0] pattern [18] = '{16'd1, 16'hFFFF, 16'd0, 16'hAAAA, 16'h5555,
                                           16'd2, 16'd300, 16'hFFFF, 16'd0, 16'd0, 16'd7,
                                           16'h8000, 16'h0001, 16'd40000, 16'd12,
                                           16'hFFFE, 16'd5, 16'hFFFF};
      wait_idle();
      set_window('0);
      send_element(16'd3, 1'b0);
      send_element(16'd9, 1'b1);
      wait_idle();
      set_window('1);
      for (int i = 0; i < 18; i++) send_element(pattern[i], i == 17);
      wait_idle();
      set_window(WINDOW_W'(MAX_WINDOW));
      // array of a single element
      send_element(16'h8000, 1'b1);
   endtask

   // stall the result side long enough to fill the block and block its input
   task automatic test_output_backpressure();
      wait_idle();
      set_window(WINDOW_W'(4));
      hold_off_request = 1'b1;
      sender_steady = 1'b1;
      for (int i = 0; i < 8; i++) send_element(pick_element(), i == 7);
      sender_steady = 1'b0;
      wait_idle();
   endtask

   // one long array of maximal elements under the full window
   task automatic test_long_max_array();
      wait_idle();
      set_window(WINDOW_W'(MAX_WINDOW));
      sender_steady = 1'b1;
      rx_steady = 1'b1;
      for (int i = 0; i < LONG_ARRAY_ITEMS; i++) begin
         send_element('1, i == LONG_ARRAY_ITEMS - 1);
      end
      sender_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // phases of random arrays, each under its own window; some arrays span phases
   task automatic test_random_arrays();
      int unsigned sent;
      int unsigned length;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         set_window(pick_window());
         repeat ($urandom_range(3, 8)) begin
            length = pick_length();
            for (int i = 0; i < length; i++) begin
               send_element(pick_element(), i == length - 1);
               sent++;
            end
         end
         // leave an array open across the window change
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 5)) begin
               send_element(pick_element(), 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin : main
      int unsigned drain_count;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      fail_count     = 0;
      result_index   = 0;
      burst_left     = 0;
      sender_steady  = 1'b0;
      rx_steady      = 1'b0;
      hold_off_request = 1'b0;
      window_setting = WINDOW_W'(1);
      clear_history();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_window();
      test_window_clamp();
      test_output_backpressure();
      test_long_max_array();
      test_random_arrays();

      // drain, then watch for stray results
      req_tvalid <= 1'b0;
      drain_count = 0;
      while (pending_results.size() != 0 && drain_count < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_count++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_results.size()));
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
